[rtl/core/qspi_pkg.sv]
// ----------------------------------------------------------------------------
// qspi_pkg
// shared types, constants and register indexes of the quadrature servo
// pi controller
// ----------------------------------------------------------------------------
package qspi_pkg;

  localparam int POSITION_BITS_DEF  = 24;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int ANGLE_W = 32;
  localparam int INTEG_W = 40;

  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd35;
  localparam logic [15:0] GAIN_CUR_RST      = 16'd57643;
  localparam logic [15:0] GAIN_PREV_RST     = 16'd57574;
  localparam logic [15:0] DEG_PER_CNT_RST   = 16'd17241;
  localparam logic [7:0]  PWM_MAX_RST       = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 3'd0,
    CFG_GAIN_CURRENT  = 3'd1,
    CFG_GAIN_PREVIOUS = 3'd2,
    CFG_DEG_PER_COUNT = 3'd3,
    CFG_PWM_MAX       = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ANG,
    ST_ERR,
    ST_MUL_CUR,
    ST_MUL_PREV,
    ST_ACC
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MSEL_ANG,
    MSEL_CUR,
    MSEL_PREV
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     angle_we;
    logic     acc_we;
    logic     finish;
  } qspi_ctl_t;

endpackage

[rtl/core/quadrature_servo_pi_controller_unit.sv]
// ----------------------------------------------------------------------------
// quadrature_servo_pi_controller_unit
// quadrature encoder position counter with incremental pi position loop
// ----------------------------------------------------------------------------
// usage
//   in_*  : one item per encoder sample (levels a/b, ms tick, reference)
//   out_* : one item per control update (direction, pwm duty, angle q8)
//   cfg_* : register writes, to be issued only while no update is running
// an item that does not close a sample period leaves the unit idle, and
// the next item can follow in the next cycle
// an item that closes a sample period runs an update over the shared
// multiplier: three products and two add steps in the states mul_ang, err,
// mul_cur, mul_prev and acc, and in_ready is low from the accept until the
// acc step ends; that step waits while the output register is still held
// the result waits in an output register; items that cause no result are
// still taken while it waits, an update stalls in its last step until the
// output register is free
// reset clears the count, timer, previous error and integrator and loads the
// register defaults
// ----------------------------------------------------------------------------
module quadrature_servo_pi_controller_unit
  import qspi_pkg::*;
#(
  parameter int POSITION_BITS  = POSITION_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_enc_a,
  input  logic                         in_enc_b,
  input  logic                         in_ms_tick,
  input  logic [7:0]                   in_reference_deg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_drive_forward,
  output logic [7:0]                   out_pwm_duty,
  output logic signed [ANGLE_W-1:0]    out_angle_q8,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int ACC_W = PROD_W + 1;
  localparam int ISUM_W = ACC_W + 1;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (GAIN_FRAC_BITS - 1);

  logic [15:0] period_r;
  logic [15:0] gain_cur_r;
  logic [15:0] gain_prev_r;
  logic [15:0] deg_per_cnt_r;
  logic [7:0]  pwm_max_r;

  qspi_ctl_t                        ctl;
  logic                             in_acc;
  logic                             update;
  logic                             out_free;
  logic signed [POSITION_BITS-1:0]  count;
  logic [7:0]                       ref_r;

  logic signed [MUL_A_W-1:0]        op_a;
  logic signed [MUL_B_W-1:0]        op_b;
  logic signed [PROD_W-1:0]         prod;
  logic signed [PROD_W-1:0]         acc_r;

  logic signed [PROD_W-1:0]         ang_sum;
  logic signed [PROD_W-1:0]         ang_shr;
  logic signed [ANGLE_W-1:0]        angle_v;
  logic signed [ANGLE_W:0]          err_diff;
  logic signed [ANGLE_W-1:0]        err_v;
  logic signed [ANGLE_W-1:0]        angle_r;
  logic signed [ANGLE_W-1:0]        err_r;
  logic signed [ANGLE_W-1:0]        prev_err_r;

  logic signed [ACC_W-1:0]          dsum;
  logic signed [ACC_W-1:0]          delta;
  logic signed [ISUM_W-1:0]         isum;
  logic signed [INTEG_W-1:0]        integ_v;
  logic signed [INTEG_W-1:0]        integ_r;
  logic signed [INTEG_W:0]          mag;
  logic [INTEG_W-8:0]               duty_full;
  logic [7:0]                       duty_v;

  logic                             out_valid_r;
  logic                             drive_r;
  logic [7:0]                       duty_r;
  logic signed [ANGLE_W-1:0]        angle_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r      <= SAMPLE_PERIOD_RST;
      gain_cur_r    <= GAIN_CUR_RST;
      gain_prev_r   <= GAIN_PREV_RST;
      deg_per_cnt_r <= DEG_PER_CNT_RST;
      pwm_max_r     <= PWM_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_PERIOD: period_r      <= cfg_wdata;
        CFG_GAIN_CURRENT:  gain_cur_r    <= cfg_wdata;
        CFG_GAIN_PREVIOUS: gain_prev_r   <= cfg_wdata;
        CFG_DEG_PER_COUNT: deg_per_cnt_r <= cfg_wdata;
        CFG_PWM_MAX:       pwm_max_r     <= cfg_wdata[7:0];
        default:           ;
      endcase
    end
  end

  assign in_ready = ctl.in_ready;
  assign in_acc   = in_valid && ctl.in_ready;
  assign out_free = !out_valid_r || out_ready;

  qspi_enc #(
    .POSITION_BITS(POSITION_BITS)
  ) u_enc (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_acc),
    .enc_a        (in_enc_a),
    .enc_b        (in_enc_b),
    .ms_tick      (in_ms_tick),
    .sample_period(period_r),
    .update       (update),
    .count_r      (count)
  );

  qspi_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .update  (update),
    .out_free(out_free),
    .ctl     (ctl)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ref_r <= in_reference_deg;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (ctl.mul_sel)
      MSEL_CUR: begin
        op_a = err_r;
        op_b = signed'({1'b0, gain_cur_r});
      end
      MSEL_PREV: begin
        op_a = prev_err_r;
        op_b = signed'({1'b0, gain_prev_r});
      end
      default: begin
        op_a = MUL_A_W'(count);
        op_b = signed'({1'b0, deg_per_cnt_r});
      end
    endcase
  end

  qspi_mul u_mul (
    .clk   (clk),
    .en    (ctl.mul_en),
    .op_a  (op_a),
    .op_b  (op_b),
    .prod_r(prod)
  );

  // angle and error
  always_comb begin
    ang_sum = prod + PROD_W'(128);
    ang_shr = ang_sum >>> 8;
    if (!ang_shr[PROD_W-1] && (|ang_shr[PROD_W-2:ANGLE_W-1])) begin
      angle_v = {1'b0, {(ANGLE_W-1){1'b1}}};
    end else if (ang_shr[PROD_W-1] && !(&ang_shr[PROD_W-2:ANGLE_W-1])) begin
      angle_v = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      angle_v = ang_shr[ANGLE_W-1:0];
    end
    err_diff = (ANGLE_W+1)'(signed'({1'b0, ref_r, 8'h00})) - (ANGLE_W+1)'(angle_v);
    if (err_diff[ANGLE_W] != err_diff[ANGLE_W-1]) begin
      err_v = err_diff[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      err_v = err_diff[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.angle_we) begin
      angle_r <= angle_v;
      err_r   <= err_v;
    end
    if (ctl.acc_we) begin
      acc_r <= prod;
    end
  end

  // integrator step
  always_comb begin
    dsum  = ACC_W'(acc_r) - ACC_W'(prod) + RND;
    delta = dsum >>> GAIN_FRAC_BITS;
    isum  = ISUM_W'(integ_r) + ISUM_W'(delta);
    if (!isum[ISUM_W-1] && (|isum[ISUM_W-2:INTEG_W-1])) begin
      integ_v = {1'b0, {(INTEG_W-1){1'b1}}};
    end else if (isum[ISUM_W-1] && !(&isum[ISUM_W-2:INTEG_W-1])) begin
      integ_v = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_v = isum[INTEG_W-1:0];
    end
    mag       = integ_v[INTEG_W-1] ? -(INTEG_W+1)'(integ_v) : (INTEG_W+1)'(integ_v);
    duty_full = mag[INTEG_W:8];
    duty_v    = (duty_full > (INTEG_W-7)'(pwm_max_r)) ? pwm_max_r : duty_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else if (ctl.finish) begin
      integ_r    <= integ_v;
      prev_err_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      drive_r     <= !integ_v[INTEG_W-1] && (|integ_v);
      duty_r      <= duty_v;
      angle_out_r <= angle_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_forward = drive_r;
  assign out_pwm_duty      = duty_r;
  assign out_angle_q8      = angle_out_r;

endmodule

[rtl/core/qspi_enc.sv]
// ----------------------------------------------------------------------------
// qspi_enc
// x4 quadrature position counter and millisecond sample period timer
// ----------------------------------------------------------------------------
module qspi_enc
  import qspi_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic                            enc_a,
  input  logic                            enc_b,
  input  logic                            ms_tick,
  input  logic [15:0]                     sample_period,
  output logic                            update,
  output logic signed [POSITION_BITS-1:0] count_r
);

  localparam logic signed [POSITION_BITS-1:0] CNT_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] CNT_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

  logic [1:0]                     levels_r;
  logic [1:0]                     levels;
  logic [1:0]                     changed;
  logic [15:0]                    ms_r;
  logic [15:0]                    ms_inc;
  logic                           cnt_up;
  logic                           cnt_dn;
  logic signed [POSITION_BITS-1:0] count_nxt;

  assign levels  = {enc_a, enc_b};
  assign changed = levels ^ levels_r;

  always_comb begin
    cnt_up = 1'b0;
    cnt_dn = 1'b0;
    unique case (changed)
      2'b10: begin
        cnt_up = (enc_a != enc_b);
        cnt_dn = (enc_a == enc_b);
      end
      2'b01: begin
        cnt_up = (enc_a == enc_b);
        cnt_dn = (enc_a != enc_b);
      end
      default: ;
    endcase
    count_nxt = count_r;
    if (cnt_up && count_r != CNT_MAX) begin
      count_nxt = count_r + POSITION_BITS'(1);
    end else if (cnt_dn && count_r != CNT_MIN) begin
      count_nxt = count_r - POSITION_BITS'(1);
    end
  end

  assign ms_inc = (ms_tick && ms_r != 16'hFFFF) ? ms_r + 16'd1 : ms_r;
  assign update = (ms_inc >= sample_period);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= 2'b00;
      count_r  <= '0;
      ms_r     <= 16'd0;
    end else if (step) begin
      levels_r <= levels;
      count_r  <= count_nxt;
      ms_r     <= update ? 16'd0 : ms_inc;
    end
  end

endmodule

[rtl/core/qspi_mul.sv]
// ----------------------------------------------------------------------------
// qspi_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module qspi_mul
  import qspi_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

endmodule

[rtl/core/qspi_fsm.sv]
// ----------------------------------------------------------------------------
// qspi_fsm
// sequencer of one control update over the shared multiplier
// ----------------------------------------------------------------------------
module qspi_fsm
  import qspi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      update,
  input  logic      out_free,
  output qspi_ctl_t ctl
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid && update) state_nxt = ST_MUL_ANG;
      ST_MUL_ANG:  state_nxt = ST_ERR;
      ST_ERR:      state_nxt = ST_MUL_CUR;
      ST_MUL_CUR:  state_nxt = ST_MUL_PREV;
      ST_MUL_PREV: state_nxt = ST_ACC;
      ST_ACC:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.mul_sel  = MSEL_ANG;
    unique case (state_r)
      ST_IDLE:     ctl.in_ready = 1'b1;
      ST_MUL_ANG: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_ANG;
      end
      ST_ERR:      ctl.angle_we = 1'b1;
      ST_MUL_CUR: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_CUR;
      end
      ST_MUL_PREV: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_PREV;
        ctl.acc_we  = 1'b1;
      end
      ST_ACC:      ctl.finish = out_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench for the quadrature servo pi controller: it drives encoder
// samples through the valid/ready input with random idle gaps and random
// result backpressure. A per-sample predictor of the counter, the ms timer
// and the incremental pi loop gives the expected direction, duty and
// angle of every control update, and each update is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import qspi_pkg::*;

  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int SETTLE_CYCLES    = 10;
  localparam int TAIL_CYCLES      = 20;
  localparam int MAX_IDLE         = 14;
  localparam int SHAFT_RUN_STEPS  = 48;
  localparam int RUN_UPDATES_NEG  = 40;
  localparam int RUN_UPDATES_POS  = 60;
  localparam int RANDOM_PHASES    = 7;
  localparam int PHASE_ITEMS      = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam logic [15:0] PERIOD_STEPS [3] = '{16'd1, 16'd2, 16'd3};
  localparam logic [7:0]  REF_CORNERS [3]  = '{8'd0, 8'd180, 8'd255};
  localparam logic [1:0]  COUNT_WALK [15]  = '{2'b00, 2'b10, 2'b11, 2'b01, 2'b00,
                                               2'b01, 2'b11, 2'b10, 2'b00, 2'b11,
                                               2'b00, 2'b10, 2'b01, 2'b01, 2'b11};

  typedef struct {
    logic               drive_forward;
    logic [7:0]         pwm_duty;
    logic signed [31:0] angle_q8;
  } servo_cmd_t;

  logic                      clk;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic                      in_enc_a         = 1'b0;
  logic                      in_enc_b         = 1'b0;
  logic                      in_ms_tick       = 1'b0;
  logic [7:0]                in_reference_deg = 8'd0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic                      out_drive_forward;
  logic [7:0]                out_pwm_duty;
  logic signed [ANGLE_W-1:0] out_angle_q8;
  logic                      cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index        = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata        = '0;

  servo_cmd_t  pending_cmds [$];
  int unsigned items_sent, updates_checked, reg_writes, mismatches, cycle_count;
  bit          send_steady, recv_steady;
  logic [1:0]  enc_levels;

  // predictor state and register copies
  logic [1:0]  pm_levels;
  longint      pm_count, pm_prev_err, pm_integ;
  logic [15:0] pm_ms;
  logic [15:0] pm_period, pm_gain_cur, pm_gain_prev, pm_deg_per_cnt;
  logic [7:0]  pm_pwm_max;

  quadrature_servo_pi_controller_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d updates outstanding", $time, pending_cmds.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint clamp_signed(longint x, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic bit predict_sample(input logic a, input logic b, input logic tick,
                                        input logic [7:0] ref_deg, output servo_cmd_t cmd);
    logic [1:0] lv, chg;
    longint     ang, err, delta, mag, duty;
    lv  = {a, b};
    chg = lv ^ pm_levels;
    if (chg == 2'b10) pm_count += (a != b) ? 1 : -1;
    else if (chg == 2'b01) pm_count += (a == b) ? 1 : -1;
    pm_count  = clamp_signed(pm_count, POSITION_BITS_DEF);
    pm_levels = lv;
    if (tick && pm_ms != 16'hFFFF) pm_ms++;
    if (pm_ms < pm_period) return 1'b0;
    pm_ms = '0;
    ang   = clamp_signed((pm_count * longint'(pm_deg_per_cnt) + 64'sd128) >>> 8, ANGLE_W);
    err   = clamp_signed(longint'(ref_deg) * 256 - ang, ANGLE_W);
    delta = longint'(pm_gain_cur) * err - longint'(pm_gain_prev) * pm_prev_err;
    delta = (delta + (64'sd1 <<< (GAIN_FRAC_BITS_DEF - 1))) >>> GAIN_FRAC_BITS_DEF;
    pm_integ    = clamp_signed(pm_integ + delta, INTEG_W);
    pm_prev_err = err;
    mag  = (pm_integ < 0) ? -pm_integ : pm_integ;
    duty = mag >>> 8;
    if (duty > longint'(pm_pwm_max)) duty = longint'(pm_pwm_max);
    cmd.drive_forward = (pm_integ > 0);
    cmd.pwm_duty      = duty[7:0];
    cmd.angle_q8      = ang[31:0];
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand_extreme16();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // all tasks below start and end at a falling edge
  task automatic send_sample(input logic a, input logic b, input logic tick,
                             input logic [7:0] ref_deg);
    int         gap;
    servo_cmd_t cmd;
    gap = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_enc_a         <= a;
    in_enc_b         <= b;
    in_ms_tick       <= tick;
    in_reference_deg <= ref_deg;
    enc_levels = {a, b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_sample(a, b, tick, ref_deg, cmd)) pending_cmds.push_back(cmd);
    items_sent++;
    @(negedge clk);
  endtask

  // one quadrature step, forward is 00 10 11 01
  task automatic move_encoder(input logic forward, input logic tick, input logic [7:0] ref_deg);
    logic [1:0] nxt;
    nxt = forward ? {~enc_levels[0], enc_levels[1]} : {enc_levels[0], ~enc_levels[1]};
    send_sample(nxt[1], nxt[0], tick, ref_deg);
  endtask

  task automatic drain_updates();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SAMPLE_PERIOD: pm_period      = val;
      CFG_GAIN_CURRENT:  pm_gain_cur    = val;
      CFG_GAIN_PREVIOUS: pm_gain_prev   = val;
      CFG_DEG_PER_COUNT: pm_deg_per_cnt = val;
      CFG_PWM_MAX:       pm_pwm_max     = val[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    // first sample with a high counts against the cleared levels
    send_sample(1'b1, 1'b0, 1'b1, 8'd90);
    repeat (39) move_encoder(1'b1, 1'b1, 8'd90);
    drain_updates();
  endtask

  task automatic test_counting_rule();
    write_reg(CFG_SAMPLE_PERIOD, 16'd0);
    write_reg(CFG_DEG_PER_COUNT, 16'hFFFF);
    for (int i = 0; i < 15; i++)
      send_sample(COUNT_WALK[i][1], COUNT_WALK[i][0], 1'(i), REF_CORNERS[i % 3]);
    drain_updates();
  endtask

  task automatic test_sample_period();
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_SAMPLE_PERIOD, PERIOD_STEPS[k]);
      repeat (10) move_encoder(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'd45);
      drain_updates();
    end
    write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
    repeat (8) move_encoder(1'b1, 1'b1, 8'd45);
    drain_updates();
    // unused index must not disturb any register
    write_reg(CFG_IDX_UNUSED, 16'($urandom));
    // timer kept counting, so the short period fires at once
    write_reg(CFG_SAMPLE_PERIOD, 16'd2);
    repeat (6) move_encoder(1'b0, 1'($urandom_range(0, 1)), 8'd45);
    drain_updates();
  endtask

  task automatic test_gain_corners();
    write_reg(CFG_SAMPLE_PERIOD, 16'd0);
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_GAIN_CURRENT, k[0] ? 16'hFFFF : 16'h0000);
      write_reg(CFG_GAIN_PREVIOUS, k[1] ? 16'hFFFF : 16'h0000);
      write_reg(CFG_DEG_PER_COUNT, (k == 2) ? 16'h0000 : 16'hFFFF);
      // upper byte of the pwm limit is dropped
      write_reg(CFG_PWM_MAX, (k == 1) ? 16'hFF00 : 16'h00FF);
      repeat (6) move_encoder(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom));
      drain_updates();
    end
  endtask

  task automatic test_shaft_runs();
    write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
    write_reg(CFG_GAIN_CURRENT, 16'hFFFF);
    write_reg(CFG_GAIN_PREVIOUS, 16'h0000);
    write_reg(CFG_DEG_PER_COUNT, 16'hFFFF);
    write_reg(CFG_PWM_MAX, 16'd200);
    // shaft run forward under the longest period
    send_steady = 1'b1;
    repeat (SHAFT_RUN_STEPS) move_encoder(1'b1, 1'b1, 8'd0);
    send_steady = 1'b0;
    drain_updates();
    write_reg(CFG_SAMPLE_PERIOD, 16'd0);
    repeat (RUN_UPDATES_NEG)
      send_sample(enc_levels[1], enc_levels[0], 1'($urandom_range(0, 1)), 8'($urandom));
    drain_updates();
    write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
    write_reg(CFG_PWM_MAX, 16'd255);
    send_steady = 1'b1;
    repeat (2 * SHAFT_RUN_STEPS) move_encoder(1'b0, 1'b1, 8'd0);
    send_steady = 1'b0;
    drain_updates();
    write_reg(CFG_SAMPLE_PERIOD, 16'd0);
    repeat (RUN_UPDATES_POS)
      send_sample(enc_levels[1], enc_levels[0], 1'($urandom_range(0, 1)), 8'($urandom));
    drain_updates();
  endtask

  task automatic test_random_traffic();
    int         fwd_pct, tick_pct, r;
    logic       tick;
    logic [7:0] ref_deg;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_SAMPLE_PERIOD, ($urandom_range(0, 3) == 0) ?
                16'($urandom_range(0, 40)) : 16'($urandom_range(0, 4)));
      write_reg(CFG_GAIN_CURRENT, rand_extreme16());
      write_reg(CFG_GAIN_PREVIOUS, rand_extreme16());
      write_reg(CFG_DEG_PER_COUNT, rand_extreme16());
      write_reg(CFG_PWM_MAX, rand_extreme16());
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      fwd_pct  = $urandom_range(20, 70);
      tick_pct = $urandom_range(30, 100);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        ref_deg = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180));
        tick    = ($urandom_range(1, 100) <= tick_pct);
        r       = $urandom_range(0, 99);
        if (r < fwd_pct) move_encoder(1'b1, tick, ref_deg);
        else if (r < 80) move_encoder(1'b0, tick, ref_deg);
        else if (r < 90) send_sample(enc_levels[1], enc_levels[0], tick, ref_deg);
        else send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), tick, ref_deg);
      end
      drain_updates();
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  // result side backpressure
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = recv_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    servo_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: update with none pending: fwd %0b duty %0d angle %0d",
                 $time, out_drive_forward, out_pwm_duty, out_angle_q8);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        updates_checked++;
        if (out_drive_forward !== want.drive_forward) begin
          $display("%0t: drive_forward expected %0b got %0b",
                   $time, want.drive_forward, out_drive_forward);
          mismatches++;
        end
        if (out_pwm_duty !== want.pwm_duty) begin
          $display("%0t: pwm_duty expected %0d got %0d", $time, want.pwm_duty, out_pwm_duty);
          mismatches++;
        end
        if (out_angle_q8 !== want.angle_q8) begin
          $display("%0t: angle_q8 expected %0d got %0d", $time, want.angle_q8, out_angle_q8);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pm_levels      = 2'b00;
    pm_count       = 0;
    pm_ms          = '0;
    pm_prev_err    = 0;
    pm_integ       = 0;
    pm_period      = SAMPLE_PERIOD_RST;
    pm_gain_cur    = GAIN_CUR_RST;
    pm_gain_prev   = GAIN_PREV_RST;
    pm_deg_per_cnt = DEG_PER_CNT_RST;
    pm_pwm_max     = PWM_MAX_RST;
    enc_levels     = 2'b00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_counting_rule();
    test_sample_period();
    test_gain_corners();
    test_shaft_runs();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d encoder samples, %0d checked control updates, %0d register writes",
             items_sent, updates_checked, reg_writes);
    $display("counting rule, period and gain corners, pwm limit, shaft runs both ways, random mix");
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/qspi_pkg.sv
rtl/core/qspi_enc.sv
rtl/core/qspi_mul.sv
rtl/core/qspi_fsm.sv
rtl/core/quadrature_servo_pi_controller_unit.sv
dv/tb_top.sv
